// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the string intern store.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: src/sis_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sis_pkg
// Sizes, codes and controller interface types of the string intern store.
// ----------------------------------------------------------------------------
package sis_pkg;

  localparam int STORE_BYTES = 4096;
  localparam int MAX_STRING  = 64;

  localparam int ADDR_W   = $clog2(STORE_BYTES);
  localparam int POS_W    = $clog2(STORE_BYTES + 2);
  localparam int SUM_W    = $clog2(STORE_BYTES + MAX_STRING + 4);
  localparam int LEN_W    = $clog2(MAX_STRING + 2);
  localparam int STG_AW   = $clog2(MAX_STRING);
  localparam int CAP_W    = 13;
  localparam int OFFSET_W = 12;
  localparam int USED_W   = 13;
  localparam int CHAR_W   = 8;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;
  localparam int PADDR_W  = 2;
  localparam int PDATA_W  = 32;

  localparam logic [OP_W-1:0] OP_CHAR     = 2'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP   = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR    = 2'd2;
  localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

  localparam logic [STATUS_W-1:0] ST_FOUND    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ADDED    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_ROOM  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_TOO_LONG = 2'd3;

  localparam logic [PADDR_W-1:0] ADDR_CAPACITY = 2'd0;
  localparam logic [CAP_W-1:0]   CAP_RESET     = 13'd4096;

  typedef struct packed {
    logic                init;
    logic                accept;
    logic                rd_head;
    logic                rd_idx;
    logic                idx_inc;
    logic                k_inc;
    logic                pos_from_idx;
    logic                wr_start;
    logic                wr_byte;
    logic                set_res;
    logic                res_use_pos;
    logic [STATUS_W-1:0] res_status;
    logic                commit_used;
    logic                load_out;
    logic                clr_string;
  } cmd_t;

  typedef struct packed {
    logic overlong;
    logic slen_zero;
    logic pos_ge_cap;
    logic rdata_zero;
    logic byte_eq;
    logic k_last;
    logic idx_oob;
    logic no_fit;
    logic wr_last;
    logic out_free;
  } stat_t;

endpackage

// File: src/string_intern_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// string_intern_store
// Interns strings into a packed byte store and returns their offsets.
// ----------------------------------------------------------------------------
// Character and clear beats are taken in the idle state. A lookup beat scans
// the store byte by byte and appends the string when it is not found and
// fits; each byte goes through the registered read of the store memory,
// which has one write port and one read port.
// After reset the block clears the head of the store in its init state
// before it accepts its first beat. A new beat may be accepted while a result
// still waits in the output register.

module string_intern_store (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sis_pkg::PADDR_W-1:0]    paddr,
  input  logic [sis_pkg::PDATA_W-1:0]    pwdata,
  output logic [sis_pkg::PDATA_W-1:0]    prdata,
  output logic                           pready,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [sis_pkg::OP_W-1:0]       operation,
  input  logic [sis_pkg::CHAR_W-1:0]     character,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [sis_pkg::STATUS_W-1:0]   status,
  output logic [sis_pkg::OFFSET_W-1:0]   offset,
  output logic [sis_pkg::USED_W-1:0]     used_bytes
);
  import sis_pkg::*;

  logic [CAP_W-1:0] capacity;
  cmd_t             cmd;
  stat_t            stat;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_CAPACITY) ? PDATA_W'(capacity) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_CAPACITY) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  sis_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .stat      (stat),
    .cmd       (cmd)
  );

  sis_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .capacity   (capacity),
    .operation  (operation),
    .character  (character),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .offset     (offset),
    .used_bytes (used_bytes)
  );

endmodule

// File: src/sis_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sis_ctrl
// Sequencer for collecting, scanning, comparing and appending strings.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sis_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [sis_pkg::OP_W-1:0]    operation,
  input  sis_pkg::stat_t              stat,
  output sis_pkg::cmd_t               cmd
);
  import sis_pkg::*;

  typedef enum logic [11:0] {
    S_INIT    = 12'b0000_0000_0001,
    S_IDLE    = 12'b0000_0000_0010,
    S_HEAD_RD = 12'b0000_0000_0100,
    S_HEAD_EV = 12'b0000_0000_1000,
    S_CMP_RD  = 12'b0000_0001_0000,
    S_CMP_EV  = 12'b0000_0010_0000,
    S_SKIP_RD = 12'b0000_0100_0000,
    S_SKIP_EV = 12'b0000_1000_0000,
    S_FIT     = 12'b0001_0000_0000,
    S_WR_RD   = 12'b0010_0000_0000,
    S_WR_WR   = 12'b0100_0000_0000,
    S_DONE    = 12'b1000_0000_0000
  } state_t;

  state_t state;
  state_t state_next;
  logic   fire;

  assign in_ready = (state == S_IDLE);
  assign fire     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.accept = fire;
    state_next = state;
    unique case (state)
      S_INIT: begin
        cmd.init   = 1'b1;
        state_next = S_IDLE;
      end
      S_IDLE: begin
        if (fire && operation == OP_LOOKUP) begin
          priority if (stat.overlong) begin
            cmd.set_res    = 1'b1;
            cmd.res_status = ST_TOO_LONG;
            state_next     = S_DONE;
          end else if (stat.slen_zero) begin
            cmd.set_res    = 1'b1;
            cmd.res_status = ST_FOUND;
            state_next     = S_DONE;
          end else begin
            state_next = S_HEAD_RD;
          end
        end
      end
      S_HEAD_RD: begin
        if (stat.pos_ge_cap) begin
          state_next = S_FIT;
        end else begin
          cmd.rd_head = 1'b1;
          state_next  = S_HEAD_EV;
        end
      end
      S_HEAD_EV: begin
        priority if (stat.rdata_zero) begin
          state_next = S_FIT;
        end else if (stat.byte_eq) begin
          cmd.idx_inc = 1'b1;
          cmd.k_inc   = 1'b1;
          state_next  = S_CMP_RD;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_SKIP_RD;
        end
      end
      S_CMP_RD: begin
        if (stat.idx_oob) begin
          cmd.pos_from_idx = 1'b1;
          state_next       = S_HEAD_RD;
        end else begin
          cmd.rd_idx = 1'b1;
          state_next = S_CMP_EV;
        end
      end
      S_CMP_EV: begin
        priority if (stat.byte_eq && stat.k_last) begin
          cmd.set_res     = 1'b1;
          cmd.res_use_pos = 1'b1;
          cmd.res_status  = ST_FOUND;
          state_next      = S_DONE;
        end else if (stat.byte_eq) begin
          cmd.idx_inc = 1'b1;
          cmd.k_inc   = 1'b1;
          state_next  = S_CMP_RD;
        end else if (stat.rdata_zero) begin
          cmd.pos_from_idx = 1'b1;
          state_next       = S_HEAD_RD;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_SKIP_RD;
        end
      end
      S_SKIP_RD: begin
        if (stat.idx_oob) begin
          cmd.pos_from_idx = 1'b1;
          state_next       = S_HEAD_RD;
        end else begin
          cmd.rd_idx = 1'b1;
          state_next = S_SKIP_EV;
        end
      end
      S_SKIP_EV: begin
        if (stat.rdata_zero) begin
          cmd.pos_from_idx = 1'b1;
          state_next       = S_HEAD_RD;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_SKIP_RD;
        end
      end
      S_FIT: begin
        if (stat.no_fit) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = ST_NO_ROOM;
          state_next     = S_DONE;
        end else begin
          cmd.wr_start = 1'b1;
          state_next   = S_WR_RD;
        end
      end
      S_WR_RD: begin
        cmd.rd_idx = 1'b1;
        state_next = S_WR_WR;
      end
      S_WR_WR: begin
        cmd.wr_byte = 1'b1;
        if (stat.wr_last) begin
          cmd.commit_used = 1'b1;
          cmd.set_res     = 1'b1;
          cmd.res_use_pos = 1'b1;
          cmd.res_status  = ST_ADDED;
          state_next      = S_DONE;
        end else begin
          cmd.idx_inc = 1'b1;
          cmd.k_inc   = 1'b1;
          state_next  = S_WR_RD;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.load_out   = 1'b1;
          cmd.clr_string = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

  `ASSERT_NEXT(a_fit_exit, clk, rst, state == S_FIT, state == S_DONE || state == S_WR_RD)
  `ASSERT_NEXT(a_result_held, clk, rst, cmd.set_res, state == S_DONE)

endmodule

// File: src/sis_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sis_dpath
// Byte store, staging buffer, scan pointers and the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sis_dpath (
  input  logic                           clk,
  input  logic                           rst,
  input  sis_pkg::cmd_t                  cmd,
  output sis_pkg::stat_t                 stat,
  input  logic [sis_pkg::CAP_W-1:0]      capacity,
  input  logic [sis_pkg::OP_W-1:0]       operation,
  input  logic [sis_pkg::CHAR_W-1:0]     character,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [sis_pkg::STATUS_W-1:0]   status,
  output logic [sis_pkg::OFFSET_W-1:0]   offset,
  output logic [sis_pkg::USED_W-1:0]     used_bytes
);
  import sis_pkg::*;

  logic [CHAR_W-1:0]   store_mem [STORE_BYTES];
  logic [CHAR_W-1:0]   stg_mem [MAX_STRING];
  logic [CHAR_W-1:0]   rdata;
  logic [CHAR_W-1:0]   stg_q;
  logic [POS_W-1:0]    pos;
  logic [POS_W-1:0]    idx;
  logic [LEN_W-1:0]    k;
  logic [LEN_W-1:0]    slen;
  logic                overlong;
  logic [USED_W-1:0]   used;
  logic [STATUS_W-1:0] res_status;
  logic [OFFSET_W-1:0] res_offset;
  logic [POS_W-1:0]    cap_eff;
  logic [SUM_W-1:0]    end_sum;
  logic [CHAR_W-1:0]   want;
  logic                k_lt;
  logic                take_char;
  logic                do_clear;
  logic                store_we;
  logic                rd_en;
  logic [ADDR_W-1:0]   store_waddr;
  logic [ADDR_W-1:0]   store_raddr;
  logic [STG_AW-1:0]   stg_raddr;

  assign cap_eff   = (int'(capacity) > STORE_BYTES) ? POS_W'(STORE_BYTES) : POS_W'(capacity);
  assign end_sum   = SUM_W'(pos) + SUM_W'(slen) + SUM_W'(2);
  assign k_lt      = (k < slen);
  assign want      = k_lt ? stg_q : '0;
  assign take_char = cmd.accept && operation == OP_CHAR && character != '0;
  assign do_clear  = cmd.accept && operation == OP_CLEAR;

  assign store_we    = cmd.init || do_clear || cmd.wr_byte;
  assign rd_en       = cmd.rd_head || cmd.rd_idx;
  assign store_waddr = cmd.wr_byte ? idx[ADDR_W-1:0] : ADDR_W'(1);
  assign store_raddr = cmd.rd_head ? pos[ADDR_W-1:0] : idx[ADDR_W-1:0];
  assign stg_raddr   = cmd.rd_head ? '0 : k[STG_AW-1:0];

  always_ff @(posedge clk) begin
    if (store_we) begin
      store_mem[store_waddr] <= cmd.wr_byte ? want : '0;
    end
    if (rd_en) begin
      rdata <= store_mem[store_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (take_char && int'(slen) < MAX_STRING) begin
      stg_mem[slen[STG_AW-1:0]] <= character;
    end
    if (rd_en) begin
      stg_q <= stg_mem[stg_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slen      <= '0;
      overlong  <= 1'b0;
      used      <= USED_W'(2);
      out_valid <= 1'b0;
    end else begin
      if (take_char) begin
        if (int'(slen) < MAX_STRING) begin
          slen <= slen + LEN_W'(1);
        end else begin
          overlong <= 1'b1;
        end
      end
      if (do_clear) begin
        used <= USED_W'(2);
      end
      if (cmd.commit_used) begin
        used <= USED_W'(end_sum);
      end
      if (cmd.clr_string) begin
        slen     <= '0;
        overlong <= 1'b0;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pos <= POS_W'(1);
    end else if (cmd.pos_from_idx) begin
      pos <= idx + POS_W'(1);
    end
    if (cmd.rd_head || cmd.wr_start) begin
      idx <= pos;
      k   <= '0;
    end else begin
      if (cmd.idx_inc) begin
        idx <= idx + POS_W'(1);
      end
      if (cmd.k_inc) begin
        k <= k + LEN_W'(1);
      end
    end
    if (cmd.set_res) begin
      res_status <= cmd.res_status;
      res_offset <= cmd.res_use_pos ? pos[OFFSET_W-1:0] : '0;
    end
    if (cmd.load_out) begin
      status     <= res_status;
      offset     <= res_offset;
      used_bytes <= used;
    end
  end

  always_comb begin
    stat            = '0;
    stat.overlong   = overlong;
    stat.slen_zero  = (slen == '0);
    stat.pos_ge_cap = (pos >= cap_eff);
    stat.rdata_zero = (rdata == '0);
    stat.byte_eq    = (rdata == want);
    stat.k_last     = (k == slen);
    stat.idx_oob    = (idx >= POS_W'(STORE_BYTES));
    stat.no_fit     = (end_sum > SUM_W'(cap_eff));
    stat.wr_last    = (k == slen + LEN_W'(1));
    stat.out_free   = !out_valid || out_ready;
  end

  `ASSERT_IMPL(a_used_range, clk, rst, 1'b1, used >= USED_W'(2) && int'(used) <= STORE_BYTES)
  `ASSERT_IMPL(a_write_span, clk, rst, cmd.wr_byte, k <= slen + LEN_W'(1))
  `ASSERT_NEXT(a_out_loaded, clk, rst, cmd.load_out, out_valid)

endmodule

// File: bench/string_intern_store_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// string_intern_store_test
// Self-checking bench for the string intern store. A directed table and a
// random stream of strings, lookups and clears drive the input channel, with
// random gaps and stalls on both channels. Every result beat is checked
// against an in-bench model of the store, and the capacity register is
// changed between phases.
// ----------------------------------------------------------------------------
module string_intern_store_test;
  import sis_pkg::*;

  typedef struct {
    logic [OP_W-1:0]     op;
    logic [CHAR_W-1:0]   ch;
    bit                  fixed;
    logic [STATUS_W-1:0] st;
    logic [OFFSET_W-1:0] off;
    logic [USED_W-1:0]   used;
  } row_t;

  typedef struct packed {
    logic [STATUS_W-1:0] st;
    logic [OFFSET_W-1:0] off;
    logic [USED_W-1:0]   used;
  } intern_result_t;

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata, prdata;
  logic pready;
  logic in_valid, in_ready;
  logic [OP_W-1:0] operation;
  logic [CHAR_W-1:0] character;
  logic out_valid, out_ready;
  logic [STATUS_W-1:0] status;
  logic [OFFSET_W-1:0] offset;
  logic [USED_W-1:0] used_bytes;

  string_intern_store i_dut (.*);

  // Model state.
  logic [7:0]  mem [STORE_BYTES];
  logic [7:0]  pending [MAX_STRING];
  int          pending_len;
  bit          pending_long;
  int          used_cnt;
  int          cap_reg;

  intern_result_t awaited[$];
  int  errors;
  int  results_seen;
  int  added_seen, found_seen, noroom_seen, long_seen;
  bit  hold_off;
  bit  stall_enable;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #1000ms;
    $display("Test completed with failures");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  function automatic bit string_at(input int p);
    for (int k = 0; k <= pending_len; k++) begin
      if (p + k >= STORE_BYTES) return 0;
      if (mem[p + k] != ((k < pending_len) ? pending[k] : 8'd0)) return 0;
    end
    return 1;
  endfunction

  // Applies one accepted beat to the model; returns 1 with a result when one is due.
  function automatic bit intern_predict(input logic [OP_W-1:0] op, input logic [7:0] ch,
                                        output intern_result_t r);
    int lim, p;
    r = '0;
    if (op == OP_CHAR) begin
      if (ch != 0) begin
        if (pending_len < MAX_STRING) pending[pending_len++] = ch;
        else pending_long = 1;
      end
      return 0;
    end
    if (op == OP_CLEAR) begin
      mem[0] = 0;
      mem[1] = 0;
      used_cnt = 2;
      return 0;
    end
    if (op != OP_LOOKUP) return 0;
    lim = (cap_reg > STORE_BYTES) ? STORE_BYTES : cap_reg;
    r.st = ST_FOUND;
    if (pending_long) r.st = ST_TOO_LONG;
    else if (pending_len != 0) begin
      p = 1;
      r.st = ST_ADDED;
      while (p < lim && mem[p] != 0) begin
        if (string_at(p)) begin
          r.st = ST_FOUND;
          r.off = p;
          break;
        end
        while (p < STORE_BYTES && mem[p] != 0) p++;
        p++;
      end
      if (r.st == ST_ADDED) begin
        if (p + pending_len + 2 > lim) r.st = ST_NO_ROOM;
        else begin
          for (int k = 0; k < pending_len; k++) mem[p + k] = pending[k];
          mem[p + pending_len] = 0;
          mem[p + pending_len + 1] = 0;
          used_cnt = p + pending_len + 2;
          r.off = p;
        end
      end
    end
    pending_len = 0;
    pending_long = 0;
    r.used = used_cnt;
    return 1;
  endfunction

  // Offers one beat and returns at the falling edge after it is accepted, with valid
  // still high; the caller lowers valid when no beat follows at once.
  task automatic send_beat(input logic [OP_W-1:0] op, input logic [7:0] ch);
    intern_result_t r;
    operation <= op;
    character <= ch;
    in_valid  <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (intern_predict(op, ch, r)) awaited.push_back(r);
    @(negedge clk);
  endtask

  task automatic send_gap();
    int n;
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    if (stall_enable && n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic write_capacity(input int value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= ADDR_CAPACITY;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cap_reg = value & 32'h1FFF;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (awaited.size() != 0) @(negedge clk);
    repeat (STORE_BYTES * 2 + 200) @(negedge clk);
  endtask

  // Receiver with random stalls and one long hold-off.
  initial begin
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (3000) @(negedge clk);
        hold_off = 0;
      end
      if (stall_enable && $urandom_range(0, 99) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(20, 80)) @(negedge clk);
      end else begin
        out_ready <= (stall_enable && $urandom_range(0, 3) == 0) ? 1'b0 : 1'b1;
        @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    intern_result_t w;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (awaited.size() == 0) begin
        report_mismatch("result beat with none due", 1, 0);
      end else begin
        w = awaited.pop_front();
        if (status != w.st) report_mismatch("status", status, w.st);
        if (offset != w.off) report_mismatch("offset", offset, w.off);
        if (used_bytes != w.used) report_mismatch("used_bytes", used_bytes, w.used);
        case (status)
          ST_FOUND:    found_seen++;
          ST_ADDED:    added_seen++;
          ST_NO_ROOM:  noroom_seen++;
          default:     long_seen++;
        endcase
      end
    end
  end

  task automatic send_string(input int len, input int alphabet);
    for (int k = 0; k < len; k++) begin
      send_beat(OP_CHAR, (alphabet == 0) ? 8'($urandom_range(1, 255))
                                         : 8'($urandom_range(1, alphabet)));
      send_gap();
    end
    send_beat(OP_LOOKUP, 8'($urandom));
    send_gap();
  endtask

  task automatic random_phase(input int items, input int alphabet, input int maxlen);
    int sent;
    int sel;
    sent = 0;
    while (sent < items) begin
      sel = $urandom_range(0, 99);
      if (sel < 80) begin
        int len;
        len = ($urandom_range(0, 29) == 0) ? $urandom_range(MAX_STRING - 1, MAX_STRING + 3)
                                             : $urandom_range(0, maxlen);
        send_string(len, alphabet);
        sent += len + 1;
      end else if (sel < 85) begin
        send_beat(OP_CLEAR, 8'($urandom));
        sent++;
      end else if (sel < 92) begin
        send_beat(OP_RESERVED, 8'($urandom));
        sent++;
      end else begin
        send_beat(OP_CHAR, (sel < 95) ? 8'd0 : 8'($urandom));
        sent++;
      end
      send_gap();
    end
  endtask

  row_t directed[$];

  initial begin
    rst = 1'b1;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    in_valid = 0; operation = OP_CHAR; character = 8'd1;
    errors = 0; results_seen = 0;
    added_seen = 0; found_seen = 0; noroom_seen = 0; long_seen = 0;
    hold_off = 0; stall_enable = 0;
    pending_len = 0; pending_long = 0; used_cnt = 2; cap_reg = CAP_RESET;
    for (int i = 0; i < STORE_BYTES; i++) mem[i] = 8'd0;
    for (int i = 0; i < MAX_STRING; i++) pending[i] = 8'd0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    directed = '{
      '{OP_LOOKUP,   8'h00, 1, ST_FOUND, 12'd0, 13'd2},
      '{OP_CHAR,     8'hFF, 0, 0, 0, 0},
      '{OP_CHAR,     8'h01, 0, 0, 0, 0},
      '{OP_LOOKUP,   8'h00, 1, ST_ADDED, 12'd1, 13'd5},
      '{OP_CHAR,     8'hFF, 0, 0, 0, 0},
      '{OP_CHAR,     8'h00, 0, 0, 0, 0},
      '{OP_CHAR,     8'h01, 0, 0, 0, 0},
      '{OP_LOOKUP,   8'hFF, 1, ST_FOUND, 12'd1, 13'd5},
      '{OP_CHAR,     8'h80, 0, 0, 0, 0},
      '{OP_RESERVED, 8'h55, 0, 0, 0, 0},
      '{OP_LOOKUP,   8'h00, 0, 0, 0, 0},
      '{OP_CHAR,     8'hFF, 0, 0, 0, 0},
      '{OP_LOOKUP,   8'h00, 0, 0, 0, 0},
      '{OP_CHAR,     8'h41, 0, 0, 0, 0},
      '{OP_CLEAR,    8'h00, 0, 0, 0, 0},
      '{OP_LOOKUP,   8'h00, 1, ST_ADDED, 12'd1, 13'd4},
      '{OP_CLEAR,    8'hAA, 0, 0, 0, 0},
      '{OP_LOOKUP,   8'h00, 1, ST_FOUND, 12'd0, 13'd2}
    };
    foreach (directed[i]) begin
      intern_result_t saved;
      int depth;
      depth = awaited.size();
      send_beat(directed[i].op, directed[i].ch);
      if (directed[i].fixed) begin
        saved = awaited[depth];
        if (saved.st != directed[i].st || saved.off != directed[i].off ||
            saved.used != directed[i].used)
          report_mismatch("directed table row", i, saved.st);
        awaited[depth] = '{directed[i].st, directed[i].off, directed[i].used};
      end
    end
    // A string longer than the staging limit.
    for (int k = 0; k < MAX_STRING + 2; k++) send_beat(OP_CHAR, 8'h7E);
    send_beat(OP_LOOKUP, 8'h00);
    drain();

    stall_enable = 1;
    hold_off = 1;
    random_phase(500, 4, 6);
    drain();

    write_capacity(3);
    random_phase(150, 0, 3);
    drain();

    write_capacity(40);
    random_phase(300, 3, 5);
    drain();

    write_capacity(13'h1FFF);
    random_phase(450, 0, 12);
    drain();

    write_capacity(300);
    random_phase(400, 2, 8);
    drain();

    $display("Covered %0d results: %0d found, %0d added, %0d no room, %0d too long,",
             results_seen, found_seen, added_seen, noroom_seen, long_seen);
    $display("over capacities of 3, 40, 300, 4096 and the largest register value.");
    if (errors == 0 && awaited.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

// File: sim.f
+incdir+src
src/sis_pkg.sv
src/sis_ctrl.sv
src/sis_dpath.sv
src/string_intern_store.sv
bench/string_intern_store_test.sv
